// File: rtl/tcsw_pkg.sv
package tcsw_pkg;

  // field widths of the channel words
  localparam int ReqTypeW  = 2;
  localparam int CharW     = 16;
  localparam int LineW     = 6;
  localparam int ColumnW   = 6;
  localparam int HeightW   = 7;

  // request types
  localparam logic [ReqTypeW-1:0] ReqChar = 2'd0;
  localparam logic [ReqTypeW-1:0] ReqEol  = 2'd1;
  localparam logic [ReqTypeW-1:0] ReqRead = 2'd2;

  // control characters
  localparam logic [CharW-1:0] CodeCr = 16'd13;
  localparam logic [CharW-1:0] CodeLf = 16'd10;

  typedef enum logic [2:0] {
    K_CHAR,
    K_CR,
    K_LF,
    K_EOL,
    K_READ,
    K_NOP
  } op_kind_e;

  // classified word as it travels from front to back
  typedef struct packed {
    op_kind_e            kind;
    logic                starts;
    logic                ends;
    logic [CharW-1:0]    code;
    logic [LineW-1:0]    read_row;
    logic [ColumnW-1:0]  read_col;
    logic                col_ok;
  } op_t;

endpackage

// File: rtl/tcsw_if.sv
interface tcsw_req_if;
  import tcsw_pkg::*;
  logic                valid;
  logic                ready;
  logic [ReqTypeW-1:0] req_type;
  logic [CharW-1:0]    char_code;
  logic                starts_call;
  logic                ends_call;
  logic [LineW-1:0]    read_row;
  logic [ColumnW-1:0]  read_col;

  modport source (output valid, req_type, char_code, starts_call, ends_call, read_row,
                  read_col, input ready);
  modport sink   (input valid, req_type, char_code, starts_call, ends_call, read_row,
                  read_col, output ready);
endinterface

interface tcsw_rsp_if;
  import tcsw_pkg::*;
  logic               valid;
  logic               ready;
  logic [CharW-1:0]   cell_char;
  logic [LineW-1:0]   cursor_line;
  logic [ColumnW-1:0] cursor_column;
  logic [LineW-1:0]   top_ring_index;
  logic               feed_deferred;

  modport source (output valid, cell_char, cursor_line, cursor_column, top_ring_index,
                  feed_deferred, input ready);
  modport sink   (input valid, cell_char, cursor_line, cursor_column, top_ring_index,
                  feed_deferred, output ready);
endinterface

interface tcsw_cfg_if;
  import tcsw_pkg::*;
  logic               valid;
  logic               ready;
  logic [HeightW-1:0] console_height;

  modport source (output valid, console_height, input ready);
  modport sink   (input valid, console_height, output ready);
endinterface

// File: rtl/tcsw_ram.sv
module tcsw_ram #(
  parameter int Width = 16,
  parameter int Depth = 3008
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: rtl/tcsw_queue.sv
module tcsw_queue #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             ready_o,
  output logic             valid_o,
  output logic [Width-1:0] data_o,
  input  logic             pop_i
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] slot_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign ready_o = (cnt_q != CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/tcsw_front.sv
module tcsw_front #(
  parameter int COLUMNS = 47
) (
  tcsw_req_if.sink       req_if,
  input  logic           busy_i,
  input  logic           q_ready_i,
  output logic           push_o,
  output tcsw_pkg::op_t  op_o
);
  import tcsw_pkg::*;

  assign req_if.ready = q_ready_i && !busy_i;
  assign push_o       = req_if.valid && req_if.ready;

  always_comb begin
    op_o.starts   = req_if.starts_call;
    op_o.ends     = req_if.ends_call;
    op_o.code     = req_if.char_code;
    op_o.read_row = req_if.read_row;
    op_o.read_col = req_if.read_col;
    op_o.col_ok   = (32'(req_if.read_col) < COLUMNS);
    unique case (req_if.req_type)
      ReqChar: begin
        if (req_if.char_code == CodeCr) begin
          op_o.kind = K_CR;
        end else if (req_if.char_code == CodeLf) begin
          op_o.kind = K_LF;
        end else begin
          op_o.kind = K_CHAR;
        end
      end
      ReqEol:  op_o.kind = K_EOL;
      ReqRead: op_o.kind = K_READ;
      default: op_o.kind = K_NOP;
    endcase
  end

endmodule

// File: rtl/tcsw_back.sv
module tcsw_back #(
  parameter int COLUMNS   = 47,
  parameter int MAX_LINES = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  tcsw_pkg::op_t  q_op_i,
  output logic           pop_o,
  output logic           busy_o,
  tcsw_cfg_if.sink       cfg_if,
  tcsw_rsp_if.source     rsp_if
);
  import tcsw_pkg::*;

  localparam int RowW   = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int HW     = RowW + 1;
  localparam int ColW   = $clog2(COLUMNS + 1);
  localparam int Depth  = MAX_LINES * COLUMNS;
  localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int ResetH = (MAX_LINES < 64) ? MAX_LINES : 64;

  typedef enum logic [6:0] {
    S_INIT = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_ACT  = 7'b0000100,
    S_POST = 7'b0001000,
    S_RD   = 7'b0010000,
    S_CLR  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

  state_e           state_q, state_d, ret_q, ret_d;
  op_t              op_q, op_d;
  logic [HW-1:0]    height_q, height_d;
  logic [RowW-1:0]  top_q, top_d, row_q, row_d;
  logic [ColW-1:0]  col_q, col_d;
  logic             pend_q, pend_d;
  logic [AddrW-1:0] clr_addr_q, clr_addr_d, clr_end_q, clr_end_d;
  logic [CharW-1:0] cell_q, cell_d;

  logic             out_valid_q, out_load, out_free;
  logic             cfg_fire, do_feed, feed_to_act, fin, f1;
  logic [HW-1:0]    row_inc, top_inc, csum, cring, rsum, rring, new_height;
  logic [31:0]      cfg_val;
  logic             scroll, row_ok;
  logic [RowW-1:0]  feed_row, feed_top;
  logic [AddrW-1:0] line_start, cur_addr, rd_addr;

  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr;
  logic [CharW-1:0] ram_wdata, ram_rdata;

  tcsw_ram #(
    .Width (CharW),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  assign busy_o       = (state_q == S_INIT);
  assign cfg_if.ready = 1'b1;
  assign cfg_fire     = cfg_if.valid;
  assign out_free     = !out_valid_q || rsp_if.ready;

  // height clamp on write
  always_comb begin
    cfg_val = 32'(cfg_if.console_height);
    if (cfg_val == 32'd0) begin
      cfg_val = 32'd1;
    end else if (cfg_val > MAX_LINES) begin
      cfg_val = 32'(MAX_LINES);
    end
    new_height = HW'(cfg_val);
  end

  // line feed from the registered cursor
  assign row_inc    = HW'(row_q) + HW'(1);
  assign top_inc    = HW'(top_q) + HW'(1);
  assign scroll     = (row_inc >= height_q);
  assign feed_row   = scroll ? RowW'(height_q - HW'(1)) : RowW'(row_inc);
  assign feed_top   = scroll ? ((top_inc >= height_q) ? '0 : RowW'(top_inc)) : top_q;
  assign line_start = AddrW'(top_q) * AddrW'(COLUMNS);

  // ring rows of cursor and read request
  assign csum     = HW'(row_q) + HW'(top_q);
  assign cring    = (csum >= height_q) ? csum - height_q : csum;
  assign cur_addr = AddrW'(cring) * AddrW'(COLUMNS) + AddrW'(col_q);
  assign row_ok   = (32'(op_q.read_row) < 32'(height_q));
  assign rsum     = HW'(RowW'(op_q.read_row)) + HW'(top_q);
  assign rring    = (rsum >= height_q) ? rsum - height_q : rsum;
  assign rd_addr  = AddrW'(rring) * AddrW'(COLUMNS) + AddrW'(op_q.read_col);

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    op_d        = op_q;
    height_d    = height_q;
    top_d       = top_q;
    row_d       = row_q;
    col_d       = col_q;
    pend_d      = pend_q;
    clr_addr_d  = clr_addr_q;
    clr_end_d   = clr_end_q;
    cell_d      = cell_q;
    pop_o       = 1'b0;
    out_load    = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = clr_addr_q;
    ram_wdata   = '0;
    do_feed     = 1'b0;
    feed_to_act = 1'b0;
    fin         = 1'b0;
    f1          = 1'b0;

    unique case (state_q)
      S_INIT: begin
        ram_we = 1'b1;
        if (clr_addr_q == clr_end_q) begin
          state_d = S_IDLE;
        end else begin
          clr_addr_d = clr_addr_q + AddrW'(1);
        end
      end
      S_IDLE: begin
        if (q_valid_i && !cfg_fire) begin
          pop_o   = 1'b1;
          op_d    = q_op_i;
          cell_d  = '0;
          state_d = S_ACT;
          // deferred feed at call start, or a character that finds the line full
          f1 = (q_op_i.starts && pend_q &&
                (q_op_i.kind == K_CHAR || q_op_i.kind == K_CR ||
                 q_op_i.kind == K_LF || q_op_i.kind == K_EOL)) ||
               (q_op_i.kind == K_CHAR && col_q >= ColW'(COLUMNS));
          if (f1) begin
            pend_d      = 1'b0;
            do_feed     = 1'b1;
            feed_to_act = 1'b1;
          end
        end
      end
      S_ACT: begin
        unique case (op_q.kind)
          K_CR: begin
            col_d = '0;
            fin   = 1'b1;
          end
          K_LF: begin
            if (op_q.ends) begin
              pend_d = 1'b1;
              fin    = 1'b1;
            end else begin
              do_feed = 1'b1;
            end
          end
          K_CHAR: begin
            ram_we    = 1'b1;
            ram_waddr = cur_addr;
            ram_wdata = op_q.code;
            col_d     = col_q + ColW'(1);
            state_d   = S_POST;
          end
          K_EOL: begin
            if (!pend_q) begin
              do_feed = 1'b1;
            end else begin
              fin = 1'b1;
            end
          end
          K_READ: begin
            ram_re  = 1'b1;
            state_d = S_RD;
          end
          default: fin = 1'b1;
        endcase
      end
      S_POST: begin
        if (col_q >= ColW'(COLUMNS)) begin
          if (op_q.ends) begin
            pend_d = 1'b1;
            fin    = 1'b1;
          end else begin
            do_feed = 1'b1;
          end
        end else begin
          fin = 1'b1;
        end
      end
      S_RD: begin
        cell_d = (row_ok && op_q.col_ok) ? ram_rdata : '0;
        fin    = 1'b1;
      end
      S_CLR: begin
        ram_we = 1'b1;
        if (clr_addr_q == clr_end_q) begin
          state_d = ret_q;
        end else begin
          clr_addr_d = clr_addr_q + AddrW'(1);
        end
      end
      S_DONE: fin = 1'b1;
      default: state_d = S_IDLE;
    endcase

    if (do_feed) begin
      row_d = feed_row;
      col_d = '0;
      top_d = feed_top;
      if (scroll) begin
        // blank the old top line before going on
        clr_addr_d = line_start;
        clr_end_d  = line_start + AddrW'(COLUMNS - 1);
        ret_d      = feed_to_act ? S_ACT : S_DONE;
        state_d    = S_CLR;
      end else if (!feed_to_act) begin
        fin = 1'b1;
      end
    end

    if (fin) begin
      if (out_free) begin
        out_load = 1'b1;
        state_d  = S_IDLE;
      end else begin
        state_d = S_DONE;
      end
    end

    if (cfg_fire) begin
      height_d   = new_height;
      top_d      = '0;
      row_d      = RowW'(new_height - HW'(1));
      col_d      = '0;
      pend_d     = 1'b0;
      clr_addr_d = '0;
      clr_end_d  = AddrW'(Depth - 1);
      state_d    = S_INIT;
      out_load   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      ret_q       <= S_IDLE;
      height_q    <= HW'(ResetH);
      top_q       <= '0;
      row_q       <= RowW'(ResetH - 1);
      col_q       <= '0;
      pend_q      <= 1'b0;
      clr_addr_q  <= '0;
      clr_end_q   <= AddrW'(Depth - 1);
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      ret_q      <= ret_d;
      height_q   <= height_d;
      top_q      <= top_d;
      row_q      <= row_d;
      col_q      <= col_d;
      pend_q     <= pend_d;
      clr_addr_q <= clr_addr_d;
      clr_end_q  <= clr_end_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    cell_q <= cell_d;
    if (out_load) begin
      rsp_if.cell_char      <= cell_d;
      rsp_if.cursor_line    <= LineW'(row_d);
      rsp_if.cursor_column  <= ColumnW'(col_d);
      rsp_if.top_ring_index <= LineW'(top_d);
      rsp_if.feed_deferred  <= pend_d;
    end
  end

  assign rsp_if.valid = out_valid_q;

endmodule

// File: rtl/text_console_scroll_writer.sv
// text console store: a ring of text lines written one character word at a time
// req_if takes request words (write character, end of puts line, read cell),
// rsp_if returns one result word per request with the cell read (zero unless a
// read) and the cursor, top ring index and deferred-feed flag after the request.
// cfg_if writes the console height; it is always ready and restarts the store.
// a two-word queue parts the decoding front from the sequencer, so requests are
// taken while a result waits on a stalled receiver; results stay in the output
// register until taken, and the sequencer stalls while a result waits there;
// the front stops taking requests once the queue fills. a scroll blanks the old
// top line through the single write port of the screen memory, either before the
// request's own work or at its end. a result becomes valid in the cycle after the
// sequencer finishes the request and finds the output register free.
// after reset, and after each height write, a clearing pass over all
// MAX_LINES * COLUMNS cells (3008 at the defaults) zeroes the memory; no request
// is taken meanwhile.
module text_console_scroll_writer #(
  parameter int COLUMNS   = 47,
  parameter int MAX_LINES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tcsw_req_if.sink    req_if,
  tcsw_rsp_if.source  rsp_if,
  tcsw_cfg_if.sink    cfg_if
);
  import tcsw_pkg::*;

  localparam int OpW = $bits(op_t);

  op_t            fr_op, q_op;
  logic [OpW-1:0] q_data;
  logic           push, pop, busy, q_ready, q_valid;

  tcsw_front #(
    .COLUMNS (COLUMNS)
  ) u_front (
    .req_if    (req_if),
    .busy_i    (busy),
    .q_ready_i (q_ready),
    .push_o    (push),
    .op_o      (fr_op)
  );

  tcsw_queue #(
    .Width (OpW),
    .Depth (2)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (fr_op),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .data_o  (q_data),
    .pop_i   (pop)
  );

  assign q_op = op_t'(q_data);

  tcsw_back #(
    .COLUMNS   (COLUMNS),
    .MAX_LINES (MAX_LINES)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_op_i    (q_op),
    .pop_o     (pop),
    .busy_o    (busy),
    .cfg_if    (cfg_if),
    .rsp_if    (rsp_if)
  );

  // a height write always starts the clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_if.valid && cfg_if.ready) |=> busy)
    else $error("height write did not start the clearing pass");

  // the sequencer only takes a word the queue holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid)
    else $error("pop from an empty queue");

  // nothing enters the queue while it is full or the store is clearing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (q_ready && !busy))
    else $error("word pushed into a full queue or during clearing");

  // no request is taken while the memory is being cleared after reset or a height write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && $past(busy)) |-> !pop)
    else $error("request taken during the clearing pass");

endmodule
